// ===== rtl/hkf_pkg.sv =====
`timescale 1ns / 1ps
package hkf_pkg;

  // Q3.12 angle constants
  localparam logic signed [35:0] AngPi    = 36'sd12868;
  localparam logic signed [35:0] AngTwoPi = 36'sd25736;
  localparam logic [31:0]        VarOne   = 32'd65536;

  localparam int MulSteps = 32;
  localparam int DivSteps = 17;
  localparam int CntW     = $clog2(MulSteps + 1);

  localparam logic [1:0] CmdGyro  = 2'd0;
  localparam logic [1:0] CmdMeas  = 2'd1;
  localparam logic [1:0] CmdCheck = 2'd2;
  localparam logic [1:0] CmdRsvd  = 2'd3;

  localparam logic [1:0] RegMeasVar = 2'd0;
  localparam logic [1:0] RegProcVar = 2'd1;
  localparam logic [1:0] RegTimeout = 2'd2;
  localparam logic [1:0] RegDecl    = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GMUL = 6'b000010,
    S_GFIN = 6'b000100,
    S_DIV  = 6'b001000,
    S_HMUL = 6'b010000,
    S_VMUL = 6'b100000
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) begin
      return 16'sh7fff;
    end else if (v < -36'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// ===== rtl/heading_kalman_filter.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: cmd; tdata: time_now, yaw_rate, mag_heading
// m_*       out  m_tvalid/m_tready    tdata: fused_heading, mag_echo, heading_variance
// apb       in   psel/penable/pready  four registers at byte addresses 0, 4, 8, 12
//
// Sequencing: check, init and no-prediction items finish in the idle state; a gyro item on
//   an initialized filter runs one bit-serial shift-add multiplier (32 steps), then a finish;
//   a measurement update runs a 17-step restoring divider for the gain,
//   then two 32-step passes of the same multiplier, each with a finishing step.
// Reset: rst is synchronous; all filter state and registers return to defaults.
// Stalls: a finished result waits in the output register; the next item is taken
//   meanwhile, and only an update that must emit a second result holds.
module heading_kalman_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] time_now, [47:32] yaw_rate, [62:48] mag_heading
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] fused_heading, [30:16] mag_echo,
                                 // [62:31] heading_variance
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hkf_pkg::state_t state;

  // configuration
  logic [31:0]        meas_var, proc_var, timeout_lim;
  logic signed [15:0] decl;

  // filter state
  logic signed [15:0] heading, pred_heading, heading_blend;
  logic [31:0]        variance, pred_var;
  logic [31:0]        last_gyro, last_meas;
  logic               gyro_seen, meas_seen, initialized, pred_ready;

  // working registers
  logic signed [14:0] meas_q;
  logic signed [16:0] innov;
  logic [32:0]        div_sum, div_rem;
  logic [16:0]        div_bits, gain;
  logic [hkf_pkg::CntW-1:0] cnt;
  logic signed [17:0] mul_a;
  logic signed [18:0] mul_hi;
  logic [31:0]        mul_lo;

  // output register
  logic               out_valid;
  logic signed [15:0] out_compass;
  logic signed [14:0] out_raw;
  logic [31:0]        out_var;

  logic               accept, wr_en, mul_last, div_last, out_free, out_load;
  logic [31:0]        in_time, dt;
  logic signed [15:0] in_rate;
  logic signed [14:0] in_meas;
  logic [32:0]        var_sum, grow;
  logic [48:0]        div_num;
  logic signed [16:0] innov_in;
  logic signed [18:0] mul_sum;
  logic signed [50:0] mul_prod, prod_rnd;
  logic signed [34:0] prod_q16;
  logic signed [35:0] pred_sum, pred_wrap1, pred_wrap2, blend_sum, comp_diff;
  logic [33:0]        div_trial, div_diff;
  logic               div_ge, innov_big;

  assign s_tready = (state == hkf_pkg::S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign in_time  = s_tdata[31:0];
  assign in_rate  = s_tdata[47:32];
  assign in_meas  = s_tdata[62:48];
  assign dt       = in_time - last_gyro;
  assign out_free = ~out_valid | m_tready;
  assign out_load = (state == hkf_pkg::S_VMUL) &&
                    (cnt == hkf_pkg::CntW'(hkf_pkg::MulSteps)) && out_free;

  // gain dividend: (P << 16) + (P + R) / 2
  assign var_sum  = {1'b0, pred_var} + {1'b0, meas_var};
  assign div_num  = {1'b0, pred_var, 16'd0} + {17'd0, var_sum[32:1]};
  assign innov_in = 17'(in_meas) - 17'(pred_heading);

  // shift-add step: signed multiplicand, multiplier bits from the low end
  assign mul_sum  = mul_hi + (mul_lo[0] ? 19'(mul_a) : 19'sd0);
  assign mul_prod = {mul_hi, mul_lo};
  assign prod_rnd = mul_prod + 51'sd32768;
  assign prod_q16 = prod_rnd[50:16];
  assign mul_last = (cnt == hkf_pkg::CntW'(hkf_pkg::MulSteps - 1));

  // restoring divider step
  assign div_trial = {div_rem, div_bits[16]};
  assign div_diff  = div_trial - {1'b0, div_sum};
  assign div_ge    = (div_sum != 33'd0) && (div_trial >= {1'b0, div_sum});
  assign div_last  = (cnt == hkf_pkg::CntW'(hkf_pkg::DivSteps - 1));

  // prediction: advance, wrap once into +-pi, saturate
  assign pred_sum   = 36'(heading) + 36'(prod_q16);
  assign pred_wrap1 = (pred_sum > hkf_pkg::AngPi) ? pred_sum - hkf_pkg::AngTwoPi : pred_sum;
  assign pred_wrap2 = (pred_wrap1 < -hkf_pkg::AngPi) ? pred_wrap1 + hkf_pkg::AngTwoPi
                                                     : pred_wrap1;
  assign grow       = {1'b0, variance} + {1'b0, proc_var};

  assign blend_sum = 36'(pred_heading) + 36'(prod_q16);
  assign innov_big = (36'(innov) > hkf_pkg::AngPi) || (36'(innov) < -hkf_pkg::AngPi);
  assign comp_diff = 36'(heading_blend) - 36'(decl);

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (paddr[3:2])
      hkf_pkg::RegMeasVar: prdata = meas_var;
      hkf_pkg::RegProcVar: prdata = proc_var;
      hkf_pkg::RegTimeout: prdata = timeout_lim;
      hkf_pkg::RegDecl:    prdata = 32'(decl);
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_var     <= 32'd655360;
      proc_var     <= 32'd655;
      timeout_lim  <= 32'd32768;
      decl         <= 16'sd0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        hkf_pkg::RegMeasVar: meas_var    <= pwdata;
        hkf_pkg::RegProcVar: proc_var    <= pwdata;
        hkf_pkg::RegTimeout: timeout_lim <= pwdata;
        hkf_pkg::RegDecl:    decl        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // output beat valid: set on a commit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hkf_pkg::S_IDLE;
      heading      <= 16'sd0;
      variance     <= 32'd0;
      pred_heading <= 16'sd0;
      pred_var     <= 32'd0;
      last_gyro    <= 32'd0;
      last_meas    <= 32'd0;
      gyro_seen    <= 1'b0;
      meas_seen    <= 1'b0;
      initialized  <= 1'b0;
      pred_ready   <= 1'b0;
      cnt          <= '0;
    end else begin
      unique case (state)
        hkf_pkg::S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            unique case (s_tuser)
              hkf_pkg::CmdGyro: begin
                gyro_seen <= 1'b1;
                last_gyro <= in_time;
                if (initialized) begin
                  mul_a  <= 18'(in_rate);
                  mul_hi <= 19'sd0;
                  mul_lo <= dt;
                  state  <= hkf_pkg::S_GMUL;
                end
              end
              hkf_pkg::CmdMeas: begin
                last_meas <= in_time;
                meas_q    <= in_meas;
                if (!meas_seen) begin
                  heading     <= 16'(in_meas);
                  variance    <= hkf_pkg::VarOne;
                  initialized <= 1'b1;
                  meas_seen   <= 1'b1;
                end else if (pred_ready) begin
                  innov    <= innov_in;
                  div_sum  <= var_sum;
                  div_rem  <= div_num[48:16] >> 1;
                  div_bits <= div_num[16:0];
                  gain     <= 17'd0;
                  state    <= hkf_pkg::S_DIV;
                end
              end
              hkf_pkg::CmdCheck: begin
                if (gyro_seen && (in_time - last_gyro) > timeout_lim) begin
                  gyro_seen <= 1'b0;
                end
                if (meas_seen && (in_time - last_meas) > timeout_lim) begin
                  meas_seen   <= 1'b0;
                  initialized <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        hkf_pkg::S_GMUL: begin
          mul_hi <= {mul_sum[18], mul_sum[18:1]};
          mul_lo <= {mul_sum[0], mul_lo[31:1]};
          cnt    <= cnt + 1'b1;
          if (mul_last) begin
            state <= hkf_pkg::S_GFIN;
          end
        end
        hkf_pkg::S_GFIN: begin
          pred_heading <= hkf_pkg::sat16(pred_wrap2);
          pred_var     <= grow[32] ? 32'hffff_ffff : grow[31:0];
          pred_ready   <= 1'b1;
          state        <= hkf_pkg::S_IDLE;
        end
        hkf_pkg::S_DIV: begin
          div_rem  <= div_ge ? div_diff[32:0] : div_trial[32:0];
          div_bits <= {div_bits[15:0], 1'b0};
          gain     <= {gain[15:0], div_ge};
          if (div_last) begin
            // gain complete: load the innovation times gain product
            mul_a  <= 18'(innov);
            mul_hi <= 19'sd0;
            mul_lo <= {15'd0, gain[15:0], div_ge};
            cnt    <= '0;
            state  <= hkf_pkg::S_HMUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        hkf_pkg::S_HMUL: begin
          if (cnt != hkf_pkg::CntW'(hkf_pkg::MulSteps)) begin
            mul_hi <= {mul_sum[18], mul_sum[18:1]};
            mul_lo <= {mul_sum[0], mul_lo[31:1]};
            cnt    <= cnt + 1'b1;
          end else begin
            heading_blend <= innov_big ? 16'(meas_q) : hkf_pkg::sat16(blend_sum);
            mul_a  <= 18'(18'sd65536 - 18'(gain));
            mul_hi <= 19'sd0;
            mul_lo <= pred_var;
            cnt    <= '0;
            state  <= hkf_pkg::S_VMUL;
          end
        end
        hkf_pkg::S_VMUL: begin
          if (cnt != hkf_pkg::CntW'(hkf_pkg::MulSteps)) begin
            mul_hi <= {mul_sum[18], mul_sum[18:1]};
            mul_lo <= {mul_sum[0], mul_lo[31:1]};
            cnt    <= cnt + 1'b1;
          end else if (out_load) begin
            // posterior is ready: commit state and load the output beat
            heading     <= heading_blend;
            variance    <= prod_rnd[47:16];
            pred_ready  <= 1'b0;
            out_compass <= hkf_pkg::sat16(comp_diff);
            out_raw     <= meas_q;
            out_var     <= prod_rnd[47:16];
            state       <= hkf_pkg::S_IDLE;
          end
        end
        default: state <= hkf_pkg::S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_var, out_raw, out_compass};

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_from_vmul: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == hkf_pkg::S_VMUL))
    else $error("result beat not from update");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == hkf_pkg::S_DIV) |-> (cnt < hkf_pkg::CntW'(hkf_pkg::DivSteps)))
    else $error("divider overran");
  a_gyro_init: assert property (@(posedge clk) disable iff (rst)
    (state == hkf_pkg::S_GMUL) |-> initialized)
    else $error("prediction without initialization");
`endif

endmodule
